>>> hdl/rational_arithmetic_unit_macros.svh
// assertion macros for the rational arithmetic unit
// depends on nothing; included by the top level
`ifndef RATIONAL_ARITHMETIC_UNIT_MACROS_SVH
`define RATIONAL_ARITHMETIC_UNIT_MACROS_SVH
`define RAU_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("rau check failed");
`define RAU_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("rau check failed");
`endif

>>> hdl/rau_pkg.sv
// types and constants for the rational arithmetic unit
// no dependencies
`default_nettype none
package rau_pkg;
	typedef enum logic [1:0] {
		KIND_ADD = 2'd0,
		KIND_SUB = 2'd1,
		KIND_MUL = 2'd2,
		KIND_DIV = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_ZERO_DEN = 2'd1,
		ST_DIV_ZERO = 2'd2,
		ST_OVERFLOW = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_LOAD,
		S_RED_A,
		S_START_B,
		S_RED_B,
		S_MUL1,
		S_MUL2,
		S_COMB,
		S_START_R,
		S_RED_R,
		S_DONE
	} state_t;

	// gcd and divide sequencer
	typedef enum logic [2:0] {
		G_IDLE,
		G_STRIP,
		G_SUB,
		G_DIVN,
		G_DIVD
	} gcd_state_t;

	typedef enum logic [1:0] {
		RED_A = 2'd0,
		RED_B = 2'd1,
		RED_R = 2'd2
	} red_sel_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic red_start;
		red_sel_t red_sel;
		logic mul1;
		logic mul2;
		logic comb;
		logic finish;
	} rau_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic zero_den;
		logic div_zero;
		logic red_busy;
	} rau_stat_t;
endpackage
`default_nettype wire

>>> hdl/rational_arithmetic_unit.sv
// Rational arithmetic unit: add, subtract, multiply or divide two fractions,
// each reduced by its gcd before and after the operation. One beat at a time:
// each of the three reduction passes (both operands, then the result) runs a
// binary gcd followed by bit-serial division of numerator and denominator by
// the gcd. Status is 0 ok, 1 zero denominator, 2 division by zero, 3 overflow;
// fields are 0 on error.
`default_nettype none
`include "rational_arithmetic_unit_macros.svh"
module rational_arithmetic_unit import rau_pkg::*; #(
	parameter int WIDTH = 32
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [1:0]         kind,
	input  wire logic signed [31:0] a_numerator,
	input  wire logic signed [31:0] a_denominator,
	input  wire logic signed [31:0] b_numerator,
	input  wire logic signed [31:0] b_denominator,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed [31:0]      result_numerator,
	output logic [30:0]             result_denominator,
	output logic [1:0]              status
);
	rau_cmd_t cmd;
	rau_stat_t stat;

	rau_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready), .stat(stat), .cmd(cmd)
	);

	rau_datapath #(.WIDTH(WIDTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat), .kind(kind),
		.a_numerator(a_numerator), .a_denominator(a_denominator),
		.b_numerator(b_numerator), .b_denominator(b_denominator),
		.result_numerator(result_numerator),
		.result_denominator(result_denominator), .status(status)
	);

	`RAU_ASSERT_IMP(a_no_overlap, in_ready, !out_valid)
	`RAU_ASSERT_NXT(a_accept_busy, in_valid && in_ready, !in_ready)
	`RAU_ASSERT_IMP(a_ok_den, out_valid && status == ST_OK, result_denominator != '0)
endmodule
`default_nettype wire

>>> hdl/rau_gcd.sv
// binary gcd reduction of a magnitude pair, then divide both parts by the gcd
// bit-serial restoring divider, one quotient bit per cycle; uses rau_pkg
`default_nettype none
module rau_gcd import rau_pkg::*; #(
	parameter int W = 64
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	input  wire logic [W-1:0] num,
	input  wire logic [W-1:0] den,
	output logic              busy,
	output logic [W-1:0]      num_out,
	output logic [W-1:0]      den_out
);
	localparam int CW = $clog2(W + 1);

	gcd_state_t st_q, st_d;
	logic [W-1:0] x_q, y_q, n_q, d_q, g_q, rem_q, quo_q, src_q;
	logic [CW-1:0] sh_q, cnt_q;
	logic [W:0] trial;

	assign busy = (st_q != G_IDLE) || start;
	assign num_out = n_q;
	assign den_out = d_q;
	assign trial = {rem_q, src_q[W-1]} - {1'b0, g_q};

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			G_IDLE: if (start) st_d = G_STRIP;
			G_STRIP: if (x_q == '0 || y_q == '0 || !(x_q[0] == 1'b0 && y_q[0] == 1'b0))
				st_d = G_SUB;
			G_SUB: if (x_q == '0 || y_q == '0) st_d = G_DIVN;
			G_DIVN: if (cnt_q == CW'(W)) st_d = G_DIVD;
			G_DIVD: if (cnt_q == CW'(W)) st_d = G_IDLE;
			default: st_d = G_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			st_q <= G_IDLE;
		else
			st_q <= st_d;
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			G_IDLE: begin
				if (start) begin
					x_q <= num;
					y_q <= den;
					n_q <= num;
					d_q <= den;
					sh_q <= '0;
				end
			end
			G_STRIP: begin
				if (x_q != '0 && y_q != '0 && x_q[0] == 1'b0 && y_q[0] == 1'b0) begin
					x_q <= x_q >> 1;
					y_q <= y_q >> 1;
					sh_q <= sh_q + 1'b1;
				end
			end
			G_SUB: begin
				if (x_q == '0 || y_q == '0) begin
					if ((x_q | y_q) == '0)
						g_q <= W'(1);
					else
						g_q <= (x_q | y_q) << sh_q;
					cnt_q <= '0;
					rem_q <= '0;
					quo_q <= '0;
					src_q <= n_q;
				end else if (x_q[0] == 1'b0) begin
					x_q <= x_q >> 1;
				end else if (y_q[0] == 1'b0) begin
					y_q <= y_q >> 1;
				end else if (x_q >= y_q) begin
					x_q <= x_q - y_q;
				end else begin
					y_q <= y_q - x_q;
				end
			end
			G_DIVN, G_DIVD: begin
				if (cnt_q == CW'(W)) begin
					if (st_q == G_DIVN) begin
						n_q <= quo_q;
						src_q <= d_q;
					end else begin
						d_q <= quo_q;
					end
					cnt_q <= '0;
					rem_q <= '0;
					quo_q <= '0;
				end else begin
					if (!trial[W]) begin
						rem_q <= trial[W-1:0];
						quo_q <= {quo_q[W-2:0], 1'b1};
					end else begin
						rem_q <= {rem_q[W-2:0], src_q[W-1]};
						quo_q <= {quo_q[W-2:0], 1'b0};
					end
					src_q <= src_q << 1;
					cnt_q <= cnt_q + 1'b1;
				end
			end
			default: ;
		endcase
	end
endmodule
`default_nettype wire

>>> hdl/rau_datapath.sv
// operand normalization, cross products, combine and result formatting
// uses rau_pkg and rau_gcd
`default_nettype none
module rau_datapath import rau_pkg::*; #(
	parameter int WIDTH = 32
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  rau_cmd_t                cmd,
	output rau_stat_t               stat,
	input  wire logic [1:0]         kind,
	input  wire logic signed [31:0] a_numerator,
	input  wire logic signed [31:0] a_denominator,
	input  wire logic signed [31:0] b_numerator,
	input  wire logic signed [31:0] b_denominator,
	output logic signed [31:0]      result_numerator,
	output logic [30:0]             result_denominator,
	output logic [1:0]              status
);
	logic [1:0] kind_q;
	logic an_q, bn_q, rneg_q, zden_q;
	logic [31:0] ann_q, adn_q, bnn_q, bdn_q;
	logic [63:0] p_q, q_q, dd_q, rn_q, rd_q;
	logic [63:0] gin_n, gin_d, gout_n, gout_d;
	logic [31:0] m0, m1, m2, m3;
	logic qneg;
	logic [63:0] limit;
	logic div_zero;
	logic red_busy;

	function automatic logic [31:0] mag(input logic [31:0] v);
		return v[31] ? (~v + 32'd1) : v;
	endfunction

	assign limit = (64'd1 << (WIDTH - 1)) - 64'd1;
	assign div_zero = (kind_q == KIND_DIV) && (bnn_q == '0);
	assign stat = '{zero_den: zden_q, div_zero: div_zero, red_busy: red_busy};

	always_comb begin
		unique case (cmd.red_sel)
			RED_A: begin
				gin_n = {32'd0, ann_q};
				gin_d = {32'd0, adn_q};
			end
			RED_B: begin
				gin_n = {32'd0, bnn_q};
				gin_d = {32'd0, bdn_q};
			end
			default: begin
				gin_n = rn_q;
				gin_d = rd_q;
			end
		endcase
	end

	rau_gcd #(.W(64)) u_gcd (
		.clk(clk), .arst_n(arst_n), .start(cmd.red_start),
		.num(gin_n), .den(gin_d), .busy(red_busy),
		.num_out(gout_n), .den_out(gout_d)
	);

	// operand ordering per kind for the two product passes
	always_comb begin
		qneg = (kind_q == KIND_SUB) ? !bn_q : bn_q;
		m0 = ann_q; m1 = bdn_q; m2 = bnn_q; m3 = adn_q;
		unique case (kind_q)
			KIND_MUL: begin m1 = bnn_q; m2 = adn_q; m3 = bdn_q; end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= kind;
			zden_q <= (a_denominator == '0) || (b_denominator == '0);
			an_q <= a_numerator[31] ^ a_denominator[31];
			bn_q <= b_numerator[31] ^ b_denominator[31];
			ann_q <= mag(a_numerator);
			adn_q <= mag(a_denominator);
			bnn_q <= mag(b_numerator);
			bdn_q <= mag(b_denominator);
		end
		if (cmd.finish && cmd.red_sel == RED_A) begin
			ann_q <= gout_n[31:0];
			adn_q <= gout_d[31:0];
		end
		if (cmd.finish && cmd.red_sel == RED_B) begin
			bnn_q <= gout_n[31:0];
			bdn_q <= gout_d[31:0];
		end
		if (cmd.mul1) begin
			p_q <= 64'(m0) * 64'(m1);
			dd_q <= 64'(adn_q) * 64'(bdn_q);
		end
		if (cmd.mul2) begin
			q_q <= 64'(m2) * 64'(m3);
		end
		if (cmd.comb) begin
			if (kind_q == KIND_MUL || kind_q == KIND_DIV) begin
				rn_q <= p_q;
				rd_q <= q_q;
				rneg_q <= an_q ^ bn_q;
			end else begin
				rd_q <= dd_q;
				if (an_q == qneg) begin
					rn_q <= p_q + q_q;
					rneg_q <= an_q;
				end else if (p_q >= q_q) begin
					rn_q <= p_q - q_q;
					rneg_q <= an_q;
				end else begin
					rn_q <= q_q - p_q;
					rneg_q <= qneg;
				end
			end
		end
		if (cmd.finish && cmd.red_sel == RED_R) begin
			if (zden_q) begin
				status <= ST_ZERO_DEN;
				result_numerator <= '0;
				result_denominator <= '0;
			end else if (div_zero) begin
				status <= ST_DIV_ZERO;
				result_numerator <= '0;
				result_denominator <= '0;
			end else if (gout_n > limit || gout_d > limit) begin
				status <= ST_OVERFLOW;
				result_numerator <= '0;
				result_denominator <= '0;
			end else begin
				status <= ST_OK;
				result_numerator <= (rneg_q && gout_n != '0) ?
					(32'd0 - gout_n[31:0]) : gout_n[31:0];
				result_denominator <= gout_d[30:0];
			end
		end
	end
endmodule
`default_nettype wire

>>> hdl/rau_ctrl.sv
// sequencing controller for the rational arithmetic unit
// uses rau_pkg
`default_nettype none
module rau_ctrl import rau_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  wire logic out_ready,
	input  rau_stat_t stat,
	output rau_cmd_t  cmd
);
	state_t st_q, st_d;
	logic err;

	assign err = stat.zero_den || stat.div_zero;

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			S_IDLE: if (in_valid) st_d = S_LOAD;
			S_LOAD: st_d = stat.zero_den ? S_RED_R : S_RED_A;
			S_RED_A: if (!stat.red_busy) st_d = S_START_B;
			S_START_B: st_d = S_RED_B;
			S_RED_B: if (!stat.red_busy) st_d = err ? S_RED_R : S_MUL1;
			S_MUL1: st_d = S_MUL2;
			S_MUL2: st_d = S_COMB;
			S_COMB: st_d = S_START_R;
			S_START_R: st_d = S_RED_R;
			S_RED_R: if (!stat.red_busy) st_d = S_DONE;
			S_DONE: if (out_ready) st_d = S_IDLE;
			default: st_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.red_sel = RED_R;
		in_ready = (st_q == S_IDLE);
		out_valid = (st_q == S_DONE);
		unique case (st_q)
			S_IDLE: cmd.load = in_valid;
			S_LOAD: begin
				cmd.red_sel = RED_A;
				cmd.red_start = !stat.zero_den;
			end
			S_RED_A: begin
				cmd.red_sel = RED_A;
				cmd.finish = !stat.red_busy;
			end
			S_START_B: begin
				cmd.red_sel = RED_B;
				cmd.red_start = 1'b1;
			end
			S_RED_B: begin
				cmd.red_sel = RED_B;
				cmd.finish = !stat.red_busy;
			end
			S_MUL1: cmd.mul1 = 1'b1;
			S_MUL2: cmd.mul2 = 1'b1;
			S_COMB: cmd.comb = 1'b1;
			S_START_R: cmd.red_start = 1'b1;
			S_RED_R: cmd.finish = !stat.red_busy;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			st_q <= S_IDLE;
		else
			st_q <= st_d;
	end
endmodule
`default_nettype wire

>>> tb/tb_rational_arithmetic_unit.sv
// self-checking testbench for the rational arithmetic unit
// predicts each result from the operands with a local exact fraction model
// depends on rau_pkg and the rational_arithmetic_unit rtl
`default_nettype none
module tb_rational_arithmetic_unit;
	import rau_pkg::*;

	localparam int NUM_RANDOM = 1830;
	localparam int STALL_LIMIT = 200000;

	typedef struct {
		logic signed [31:0] num;
		logic [30:0] den;
		status_t st;
	} fraction_result_t;

	class fraction_scoreboard;
		fraction_result_t pending[$];
		int errors;

		function new();
			errors = 0;
		endfunction

		function longint unsigned gcd64(longint unsigned x, longint unsigned y);
			while (x != 0 && y != 0) begin
				if (x > y) x = x % y;
				else y = y % x;
			end
			return x + y;
		endfunction

		function longint unsigned mag32(logic [31:0] v, output bit neg);
			neg = v[31];
			return v[31] ? (64'h1_0000_0000 - {32'd0, v}) : {32'd0, v};
		endfunction

		function void reduce_frac(inout bit neg, inout longint unsigned n,
				inout longint unsigned d);
			longint unsigned g;
			g = gcd64(n, d);
			if (g == 0) g = 1;
			n = n / g;
			d = d / g;
			if (n == 0) neg = 0;
		endfunction

		function void note_operands(kind_t k, logic [31:0] an, logic [31:0] ad,
				logic [31:0] bn, logic [31:0] bd);
			fraction_result_t r;
			bit nn, dn, a_neg, b_neg, q_neg, r_neg;
			longint unsigned a_n, a_d, b_n, b_d, p, q, r_n, r_d;
			longint unsigned lim;
			lim = 64'h7FFF_FFFF;
			r.num = 0;
			r.den = 0;
			r.st = ST_OK;
			if (ad == 0 || bd == 0) begin
				r.st = ST_ZERO_DEN;
			end else begin
				a_n = mag32(an, nn);
				a_d = mag32(ad, dn);
				a_neg = nn ^ dn;
				reduce_frac(a_neg, a_n, a_d);
				b_n = mag32(bn, nn);
				b_d = mag32(bd, dn);
				b_neg = nn ^ dn;
				reduce_frac(b_neg, b_n, b_d);
				if (k == KIND_DIV && b_n == 0) begin
					r.st = ST_DIV_ZERO;
				end else begin
					if (k == KIND_ADD || k == KIND_SUB) begin
						p = a_n * b_d;
						q = b_n * a_d;
						q_neg = (k == KIND_SUB) ? !b_neg : b_neg;
						if (a_neg == q_neg) begin
							r_n = p + q;
							r_neg = a_neg;
						end else if (p >= q) begin
							r_n = p - q;
							r_neg = a_neg;
						end else begin
							r_n = q - p;
							r_neg = q_neg;
						end
						r_d = a_d * b_d;
					end else if (k == KIND_MUL) begin
						r_neg = a_neg ^ b_neg;
						r_n = a_n * b_n;
						r_d = a_d * b_d;
					end else begin
						r_neg = a_neg ^ b_neg;
						r_n = a_n * b_d;
						r_d = a_d * b_n;
					end
					reduce_frac(r_neg, r_n, r_d);
					if (r_n > lim || r_d > lim) begin
						r.st = ST_OVERFLOW;
					end else begin
						r.num = r_neg ? -r_n[31:0] : r_n[31:0];
						r.den = r_d[30:0];
					end
				end
			end
			pending.push_back(r);
		endfunction

		function void check_result(logic [31:0] n, logic [30:0] d, logic [1:0] s);
			fraction_result_t e;
			if (pending.size() == 0) begin
				$error("result beat with nothing expected");
				errors++;
				return;
			end
			e = pending.pop_front();
			if (n !== e.num) begin
				$error("result_numerator expected %0d got %0d", e.num, $signed(n));
				errors++;
			end
			if (d !== e.den) begin
				$error("result_denominator expected %0d got %0d", e.den, d);
				errors++;
			end
			if (s !== e.st) begin
				$error("status expected %0d got %0d", e.st, s);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_ready;
	logic [1:0] kind = '0;
	logic signed [31:0] a_numerator = '0;
	logic signed [31:0] a_denominator = '0;
	logic signed [31:0] b_numerator = '0;
	logic signed [31:0] b_denominator = '0;
	logic out_valid;
	logic out_ready = 0;
	logic signed [31:0] result_numerator;
	logic [30:0] result_denominator;
	logic [1:0] status;

	fraction_scoreboard board = new();
	bit calm = 0;
	bit hold_off = 0;
	int idle_cycles = 0;

	rational_arithmetic_unit dut (.*);

	always begin
		#1 clk = 1;
		#1 clk = 0;
	end

	function logic [31:0] pick_value();
		case ($urandom_range(0, 9))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'h8000_0001;
			3: return '0;
			4, 5: return $urandom_range(0, 40) - 20;
			6: return $urandom_range(0, 2000) - 1000;
			7: return ($urandom_range(1, 500) * $urandom_range(1, 500)) *
				($urandom_range(0, 1) ? 1 : -1);
			default: return $urandom();
		endcase
	endfunction

	task automatic send_operands(kind_t k, logic [31:0] an, logic [31:0] ad,
			logic [31:0] bn, logic [31:0] bd);
		while (!calm && $urandom_range(0, 99) < 14) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		kind <= k;
		a_numerator <= an;
		a_denominator <= ad;
		b_numerator <= bn;
		b_denominator <= bd;
		do @(posedge clk); while (!in_ready);
		board.note_operands(k, an, ad, bn, bd);
	endtask

	// receiver
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				board.check_result(result_numerator, result_denominator, status);
			out_ready <= !hold_off && (calm || $urandom_range(0, 99) >= 14);
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > STALL_LIMIT) begin
			$display("tb_rational_arithmetic_unit: done, errors");
			$finish;
		end
	end

	// long receiver hold-off so the block backs up
	initial begin
		wait (arst_n);
		repeat (3000) @(posedge clk);
		hold_off = 1;
		repeat (4000) @(posedge clk);
		hold_off = 0;
	end

	initial begin
		kind_t k;
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		for (int i = 0; i < 4; i++) begin
			k = kind_t'(i);
			send_operands(k, 1, 2, 1, 3);
			send_operands(k, 32'h8000_0000, 1, 32'h7FFF_FFFF, 32'h8000_0000);
			send_operands(k, 6, -4, 0, 7);
			send_operands(k, 32'h7FFF_FFFF, 1, 32'h7FFF_FFFF, 1);
			send_operands(k, 5, 0, 1, 1);
		end
		send_operands(KIND_ADD, 1, 1, 1, 32'h0);
		send_operands(KIND_MUL, 32'h8000_0000, 32'h8000_0000, -3, -9);
		send_operands(KIND_DIV, 32'hFFFF_FFFF, 32'h8000_0001, 2, 32'h8000_0000);
		for (int i = 0; i < NUM_RANDOM; i++) begin
			calm = (i >= 800 && i < 1000);
			k = kind_t'($urandom_range(0, 3));
			send_operands(k, pick_value(),
				($urandom_range(0, 30) == 0) ? 32'h0 : pick_value() | 32'h1 << $urandom_range(0, 31),
				pick_value(),
				($urandom_range(0, 30) == 0) ? 32'h0 : pick_value() | 32'h1 << $urandom_range(0, 31));
		end
		calm = 0;
		in_valid <= 0;
		wait (board.pending.size() == 0);
		repeat (1000) @(posedge clk);
		if (board.errors == 0)
			$display("tb_rational_arithmetic_unit: done, clean");
		else
			$display("tb_rational_arithmetic_unit: done, errors");
		$finish;
	end
endmodule
`default_nettype wire
